// ----- sv/cpu65x_pkg.sv -----
// ----------------------------------------------------------------------------
// cpu65x_pkg - shared types and constants of the 6502 execute unit
// Operation codes, write kinds, status bit positions and small ALU helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cpu65x_pkg;

    typedef logic [6:0] t_op;

    localparam t_op OP_ADC = 7'd0;
    localparam t_op OP_AND = 7'd1;
    localparam t_op OP_ASL = 7'd2;
    localparam t_op OP_BCC = 7'd3;
    localparam t_op OP_BCS = 7'd4;
    localparam t_op OP_BEQ = 7'd5;
    localparam t_op OP_BIT = 7'd6;
    localparam t_op OP_BMI = 7'd7;
    localparam t_op OP_BNE = 7'd8;
    localparam t_op OP_BPL = 7'd9;
    localparam t_op OP_BVC = 7'd10;
    localparam t_op OP_BVS = 7'd11;
    localparam t_op OP_CLC = 7'd12;
    localparam t_op OP_CLD = 7'd13;
    localparam t_op OP_CLI = 7'd14;
    localparam t_op OP_CLV = 7'd15;
    localparam t_op OP_CMP = 7'd16;
    localparam t_op OP_CPX = 7'd17;
    localparam t_op OP_CPY = 7'd18;
    localparam t_op OP_DEC = 7'd19;
    localparam t_op OP_DEX = 7'd20;
    localparam t_op OP_DEY = 7'd21;
    localparam t_op OP_EOR = 7'd22;
    localparam t_op OP_INC = 7'd23;
    localparam t_op OP_INX = 7'd24;
    localparam t_op OP_INY = 7'd25;
    localparam t_op OP_LDA = 7'd26;
    localparam t_op OP_LDX = 7'd27;
    localparam t_op OP_LDY = 7'd28;
    localparam t_op OP_LSR = 7'd29;
    localparam t_op OP_NOP = 7'd30;
    localparam t_op OP_ORA = 7'd31;
    localparam t_op OP_PHA = 7'd32;
    localparam t_op OP_PHP = 7'd33;
    localparam t_op OP_PLA = 7'd34;
    localparam t_op OP_PLP = 7'd35;
    localparam t_op OP_ROL = 7'd36;
    localparam t_op OP_ROR = 7'd37;
    localparam t_op OP_SBC = 7'd38;
    localparam t_op OP_SEC = 7'd39;
    localparam t_op OP_SED = 7'd40;
    localparam t_op OP_SEI = 7'd41;
    localparam t_op OP_STA = 7'd42;
    localparam t_op OP_STX = 7'd43;
    localparam t_op OP_STY = 7'd44;
    localparam t_op OP_TAX = 7'd45;
    localparam t_op OP_TAY = 7'd46;
    localparam t_op OP_TSX = 7'd47;
    localparam t_op OP_TXA = 7'd48;
    localparam t_op OP_TXS = 7'd49;
    localparam t_op OP_TYA = 7'd50;
    localparam t_op OP_SLO = 7'd51;
    localparam t_op OP_RLA = 7'd52;
    localparam t_op OP_SAX = 7'd53;
    localparam t_op OP_SRE = 7'd54;
    localparam t_op OP_RRA = 7'd55;
    localparam t_op OP_LAX = 7'd56;
    localparam t_op OP_DCP = 7'd57;
    localparam t_op OP_ISC = 7'd58;
    localparam t_op OP_ANC = 7'd59;
    localparam t_op OP_ASR = 7'd60;
    localparam t_op OP_ARR = 7'd61;
    localparam t_op OP_ANE = 7'd62;
    localparam t_op OP_LXA = 7'd63;
    localparam t_op OP_AXS = 7'd64;
    localparam t_op OP_HLT = 7'd65;

    typedef enum logic [1:0] {
        WK_NONE  = 2'd0,
        WK_EA    = 2'd1,
        WK_PUSH  = 2'd2
    } t_wkind;

    typedef enum logic [2:0] {
        RMW_ASL = 3'd0,
        RMW_LSR = 3'd1,
        RMW_ROL = 3'd2,
        RMW_ROR = 3'd3,
        RMW_INC = 3'd4,
        RMW_DEC = 3'd5
    } t_rmw;

    // status bit positions (NV1BDIZC)
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_B = 4;
    localparam int FLAG_U = 5;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [7:0] SP_RESET    = 8'hFD;
    localparam logic [7:0] FLAGS_RESET = 8'h24;

    // shift/rotate/inc/dec: returns {carry out, result}; inc/dec pass carry in
    function automatic logic [8:0] rmw_op(input t_rmw kind, input logic [7:0] v,
                                          input logic cin);
        logic [8:0] res;
        begin
            unique case (kind)
                RMW_ASL: res = {v[7], v[6:0], 1'b0};
                RMW_LSR: res = {v[0], 1'b0, v[7:1]};
                RMW_ROL: res = {v[7], v[6:0], cin};
                RMW_ROR: res = {v[0], cin, v[7:1]};
                RMW_INC: res = {cin, v + 8'd1};
                RMW_DEC: res = {cin, v - 8'd1};
                default: res = {cin, v};
            endcase
            return res;
        end
    endfunction

    // binary add with carry: returns {carry, overflow, sum}
    function automatic logic [9:0] add_op(input logic [7:0] a, input logic [7:0] v,
                                          input logic cin);
        logic [8:0] sum;
        logic       ovf;
        begin
            sum = {1'b0, a} + {1'b0, v} + {8'd0, cin};
            ovf = ~(a[7] ^ v[7]) & (a[7] ^ sum[7]);
            return {sum[8], ovf, sum[7:0]};
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/cpu6502_execute_unit.sv -----
// ----------------------------------------------------------------------------
// cpu6502_execute_unit - 6502 execute stage, binary arithmetic only
// Holds A, X, Y, SP, P and a sticky halt flag; executes one decoded
// operation per item, documented and undocumented, and reports the memory
// write request, the branch decision and the register file after the step.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready   | opcode, operand, acc mode
//  out     | output    | o_out_valid / i_out_ready | write req, branch, registers
//
//  Path: an accepted item passes the input register, then execute into the
//  architectural registers and the result register.
//  Throughput: one item per clock while results are taken; the execute step reads
//  the registers the previous item just wrote, so there is no hazard between items.
//  Stalls: a held result blocks execute; the input register then fills and
//  o_in_ready drops. Result payload stays stable while waiting.
//  Reset (synchronous, active low): A=X=Y=0, SP=0xFD, P=0x24, not halted,
//  both stages empty.
//
`default_nettype none

module cpu6502_execute_unit (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire cpu65x_pkg::t_op         i_opcode,
    input  wire logic [7:0]              i_operand_value,
    input  wire logic                    i_accumulator_mode,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [1:0]                   o_write_kind,
    output logic [7:0]                   o_write_data,
    output logic                         o_branch_taken,
    output logic [7:0]                   o_acc_out,
    output logic [7:0]                   o_index_x_out,
    output logic [7:0]                   o_index_y_out,
    output logic [7:0]                   o_stack_ptr_out,
    output logic [7:0]                   o_flags_out,
    output logic                         o_halted
);
    import cpu65x_pkg::*;

    // input register
    logic       r_in_valid;
    t_op        r_op;
    logic [7:0] r_m;
    logic       r_amode;

    // architectural state
    logic [7:0] r_a, r_x, r_y, r_sp, r_p;
    logic       r_halt;

    // result register (registers come straight from architectural state,
    // which only moves when a new result is loaded)
    logic       r_out_valid;
    t_wkind     r_wk;
    logic [7:0] r_wd;
    logic       r_br;

    logic       exec_fire;

    // next-state values of the execute step
    logic [7:0] n_a, n_x, n_y, n_sp, n_p;
    logic       n_halt;
    t_wkind     n_wk;
    logic [7:0] n_wd;
    logic       n_br;

    // shared datapath pieces
    t_rmw       rmw_kind;
    logic       rmw_on_acc;
    logic [7:0] rmw_src;
    logic [8:0] rmw_res;
    logic [7:0] add_val;
    logic       add_cin;
    logic [9:0] add_res;
    logic [7:0] and_ax;
    logic [7:0] cmp_reg;
    logic [7:0] cmp_val;
    logic [8:0] cmp_diff;
    logic [7:0] arr_val;

    assign exec_fire  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || exec_fire;

    // read-modify-write unit: one shifter/incrementer shared by all RMW ops
    always_comb begin
        unique case (r_op)
            OP_LSR, OP_SRE: rmw_kind = RMW_LSR;
            OP_ROL, OP_RLA: rmw_kind = RMW_ROL;
            OP_ROR, OP_RRA: rmw_kind = RMW_ROR;
            OP_INC, OP_ISC: rmw_kind = RMW_INC;
            OP_DEC, OP_DCP: rmw_kind = RMW_DEC;
            default:        rmw_kind = RMW_ASL;
        endcase
    end

    // only the documented six honor accumulator mode
    assign rmw_on_acc = r_amode && (r_op == OP_ASL || r_op == OP_LSR || r_op == OP_ROL ||
                                    r_op == OP_ROR || r_op == OP_INC || r_op == OP_DEC);
    assign rmw_src    = rmw_on_acc ? r_a : r_m;
    assign rmw_res    = rmw_op(rmw_kind, rmw_src, r_p[FLAG_C]);

    // adder: SBC and ISC add the complement; RRA and ISC take the RMW result
    always_comb begin
        add_cin = r_p[FLAG_C];
        unique case (r_op)
            OP_SBC:  add_val = ~r_m;
            OP_RRA: begin
                add_val = rmw_res[7:0];
                add_cin = rmw_res[8];
            end
            OP_ISC:  add_val = ~rmw_res[7:0];
            default: add_val = r_m;
        endcase
    end
    assign add_res = add_op(r_a, add_val, add_cin);

    assign and_ax = r_a & r_x;

    // comparator: CMP/CPX/CPY, DCP against the decremented byte, AXS on A&X
    always_comb begin
        cmp_val = r_m;
        unique case (r_op)
            OP_CPX:  cmp_reg = r_x;
            OP_CPY:  cmp_reg = r_y;
            OP_AXS:  cmp_reg = and_ax;
            OP_DCP: begin
                cmp_reg = r_a;
                cmp_val = rmw_res[7:0];
            end
            default: cmp_reg = r_a;
        endcase
    end
    assign cmp_diff = {1'b0, cmp_reg} - {1'b0, cmp_val};

    assign arr_val = {r_p[FLAG_C], (r_a[7:1] & r_m[7:1])};

    // execute step
    always_comb begin
        n_a    = r_a;
        n_x    = r_x;
        n_y    = r_y;
        n_sp   = r_sp;
        n_p    = r_p;
        n_halt = r_halt;
        n_wk   = WK_NONE;
        n_wd   = 8'h00;
        n_br   = 1'b0;

        if (!r_halt) begin
            unique case (r_op)
                OP_ADC, OP_SBC: begin
                    n_a         = add_res[7:0];
                    n_p[FLAG_C] = add_res[9];
                    n_p[FLAG_V] = add_res[8];
                    n_p[FLAG_Z] = (add_res[7:0] == 8'h00);
                    n_p[FLAG_N] = add_res[7];
                end
                OP_AND: n_a = r_a & r_m;
                OP_EOR: n_a = r_a ^ r_m;
                OP_ORA: n_a = r_a | r_m;
                OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_INC, OP_DEC: begin
                    n_p[FLAG_C] = rmw_res[8];
                    n_p[FLAG_Z] = (rmw_res[7:0] == 8'h00);
                    n_p[FLAG_N] = rmw_res[7];
                    if (rmw_on_acc) begin
                        n_a = rmw_res[7:0];
                    end else begin
                        n_wk = WK_EA;
                        n_wd = rmw_res[7:0];
                    end
                end
                OP_BCC: n_br = !r_p[FLAG_C];
                OP_BCS: n_br = r_p[FLAG_C];
                OP_BEQ: n_br = r_p[FLAG_Z];
                OP_BNE: n_br = !r_p[FLAG_Z];
                OP_BMI: n_br = r_p[FLAG_N];
                OP_BPL: n_br = !r_p[FLAG_N];
                OP_BVC: n_br = !r_p[FLAG_V];
                OP_BVS: n_br = r_p[FLAG_V];
                OP_BIT: begin
                    n_p[FLAG_Z] = ((r_a & r_m) == 8'h00);
                    n_p[FLAG_V] = r_m[6];
                    n_p[FLAG_N] = r_m[7];
                end
                OP_CLC: n_p[FLAG_C] = 1'b0;
                OP_CLD: n_p[FLAG_D] = 1'b0;
                OP_CLI: n_p[FLAG_I] = 1'b0;
                OP_CLV: n_p[FLAG_V] = 1'b0;
                OP_SEC: n_p[FLAG_C] = 1'b1;
                OP_SED: n_p[FLAG_D] = 1'b1;
                OP_SEI: n_p[FLAG_I] = 1'b1;
                OP_CMP, OP_CPX, OP_CPY: begin
                    n_p[FLAG_C] = !cmp_diff[8];
                    n_p[FLAG_Z] = (cmp_diff[7:0] == 8'h00);
                    n_p[FLAG_N] = cmp_diff[7];
                end
                OP_DEX: n_x = r_x - 8'd1;
                OP_DEY: n_y = r_y - 8'd1;
                OP_INX: n_x = r_x + 8'd1;
                OP_INY: n_y = r_y + 8'd1;
                OP_LDA: n_a = r_m;
                OP_LDX: n_x = r_m;
                OP_LDY: n_y = r_m;
                OP_NOP: n_br = 1'b0;
                OP_PHA: begin
                    n_wk = WK_PUSH;
                    n_wd = r_a;
                    n_sp = r_sp - 8'd1;
                end
                OP_PHP: begin
                    n_wk = WK_PUSH;
                    n_wd = r_p | 8'h30;
                    n_sp = r_sp - 8'd1;
                end
                OP_PLA: begin
                    n_sp = r_sp + 8'd1;
                    n_a  = r_m;
                end
                OP_PLP: begin
                    n_sp = r_sp + 8'd1;
                    n_p  = r_m;
                end
                OP_STA: begin
                    n_wk = WK_EA;
                    n_wd = r_a;
                end
                OP_STX: begin
                    n_wk = WK_EA;
                    n_wd = r_x;
                end
                OP_STY: begin
                    n_wk = WK_EA;
                    n_wd = r_y;
                end
                OP_TAX: n_x  = r_a;
                OP_TAY: n_y  = r_a;
                OP_TSX: n_x  = r_sp;
                OP_TXA: n_a  = r_x;
                OP_TXS: n_sp = r_x;
                OP_TYA: n_a  = r_y;
                OP_SLO, OP_RLA, OP_SRE: begin
                    n_wk        = WK_EA;
                    n_wd        = rmw_res[7:0];
                    n_p[FLAG_C] = rmw_res[8];
                    priority case (r_op)
                        OP_SLO:  n_a = r_a | rmw_res[7:0];
                        OP_RLA:  n_a = r_a & rmw_res[7:0];
                        default: n_a = r_a ^ rmw_res[7:0];
                    endcase
                end
                OP_RRA, OP_ISC: begin
                    n_wk        = WK_EA;
                    n_wd        = rmw_res[7:0];
                    n_a         = add_res[7:0];
                    n_p[FLAG_C] = add_res[9];
                    n_p[FLAG_V] = add_res[8];
                    n_p[FLAG_Z] = (add_res[7:0] == 8'h00);
                    n_p[FLAG_N] = add_res[7];
                end
                OP_SAX: begin
                    n_wk = WK_EA;
                    n_wd = and_ax;
                end
                OP_LAX, OP_LXA: begin
                    n_a = r_m;
                    n_x = r_m;
                end
                OP_DCP: begin
                    n_wk        = WK_EA;
                    n_wd        = rmw_res[7:0];
                    n_p[FLAG_C] = !cmp_diff[8];
                    n_p[FLAG_Z] = (cmp_diff[7:0] == 8'h00);
                    n_p[FLAG_N] = cmp_diff[7];
                end
                OP_ANC: begin
                    n_a         = r_a & r_m;
                    n_p[FLAG_C] = r_a[7] & r_m[7];
                end
                OP_ASR: begin
                    n_a         = {1'b0, (r_a[7:1] & r_m[7:1])};
                    n_p[FLAG_C] = r_a[0] & r_m[0];
                end
                OP_ARR: begin
                    n_a         = arr_val;
                    n_p[FLAG_C] = arr_val[6];
                    n_p[FLAG_V] = arr_val[6] ^ arr_val[5];
                end
                OP_ANE: n_a = r_x & r_m;
                OP_AXS: begin
                    n_x         = cmp_diff[7:0];
                    n_p[FLAG_C] = !cmp_diff[8];
                    n_p[FLAG_Z] = (cmp_diff[7:0] == 8'h00);
                    n_p[FLAG_N] = cmp_diff[7];
                end
                OP_HLT: n_halt = 1'b1;
                default: n_br = 1'b0;
            endcase

            // N/Z from the register that a load, logic, transfer or index inc/dec op wrote
            unique case (r_op)
                OP_AND, OP_EOR, OP_ORA, OP_LDA, OP_PLA, OP_TXA, OP_TYA, OP_SLO,
                OP_RLA, OP_SRE, OP_LAX, OP_LXA, OP_ANC, OP_ASR, OP_ARR, OP_ANE: begin
                    n_p[FLAG_Z] = (n_a == 8'h00);
                    n_p[FLAG_N] = n_a[7];
                end
                OP_DEX, OP_INX, OP_LDX, OP_TAX, OP_TSX: begin
                    n_p[FLAG_Z] = (n_x == 8'h00);
                    n_p[FLAG_N] = n_x[7];
                end
                OP_DEY, OP_INY, OP_LDY, OP_TAY: begin
                    n_p[FLAG_Z] = (n_y == 8'h00);
                    n_p[FLAG_N] = n_y[7];
                end
                default: n_halt = n_halt;
            endcase

            n_p[FLAG_B] = 1'b0;
            n_p[FLAG_U] = 1'b1;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_op    <= i_opcode;
            r_m     <= i_operand_value;
            r_amode <= i_accumulator_mode;
        end
    end

    // architectural state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a         <= 8'h00;
            r_x         <= 8'h00;
            r_y         <= 8'h00;
            r_sp        <= SP_RESET;
            r_p         <= FLAGS_RESET;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (exec_fire) begin
                r_a    <= n_a;
                r_x    <= n_x;
                r_y    <= n_y;
                r_sp   <= n_sp;
                r_p    <= n_p;
                r_halt <= n_halt;
            end
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (exec_fire) begin
            r_wk <= n_wk;
            r_wd <= n_wd;
            r_br <= n_br;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_kind    = r_wk;
    assign o_write_data    = r_wd;
    assign o_branch_taken  = r_br;
    assign o_acc_out       = r_a;
    assign o_index_x_out   = r_x;
    assign o_index_y_out   = r_y;
    assign o_stack_ptr_out = r_sp;
    assign o_flags_out     = r_p;
    assign o_halted        = r_halt;

    // halt is sticky until reset
    a_halt_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared without reset");

    // once halted, a result requests nothing and takes no branch
    a_halt_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_halt |-> (r_wk == WK_NONE) && !r_br)
        else $error("halted unit reported activity");

    // a branch decision never comes with a write request
    a_branch_no_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_br |-> (r_wk == WK_NONE))
        else $error("branch result with write request");

    // architectural registers move only when a result is loaded
    a_state_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> $stable(r_a) && $stable(r_sp) && $stable(r_p))
        else $error("state changed while result stalled");

    // P always reads with B clear and bit 5 set
    a_flags_form : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_fire |=> r_p[FLAG_U] && !r_p[FLAG_B])
        else $error("status register malformed");

endmodule

`default_nettype wire

// ----- dv/tb_cpu6502_execute_unit.sv -----
// ----------------------------------------------------------------------------
// tb_cpu6502_execute_unit - self-checking bench for the 6502 execute unit
// Feeds decoded operations through the valid/ready input channel with random
// gaps, applies random back-pressure on the result channel, and checks every
// result field against a software copy of A, X, Y, SP, P and the halt flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_cpu6502_execute_unit;

    import cpu65x_pkg::*;

    // One result item as the unit reports it
    typedef struct packed {
        t_wkind     wkind;
        logic [7:0] wdata;
        logic       taken;
        logic [7:0] acc;
        logic [7:0] ix;
        logic [7:0] iy;
        logic [7:0] sp;
        logic [7:0] p;
        logic       halt;
    } t_step_out;

    // Tracks the architectural registers and queues the result due for each
    // accepted item; results retire strictly in order.
    class regfile_tracker;
        logic [7:0] acc, ix, iy, sp, p;
        logic       halt;
        t_step_out  due_q[$];
        int         failures, issued, retired, writes, taken;

        function new();
            acc = 8'h00;
            ix = 8'h00;
            iy = 8'h00;
            sp = SP_RESET;
            p = FLAGS_RESET;
            halt = 1'b0;
            failures = 0;
            issued = 0;
            retired = 0;
            writes = 0;
            taken = 0;
        endfunction

        function void set_nz(logic [7:0] v);
            p[FLAG_Z] = (v == 8'h00);
            p[FLAG_N] = v[7];
        endfunction

        // binary only, D flag never matters
        function void add_to_acc(logic [7:0] v);
            logic [8:0] sum;
            sum = {1'b0, acc} + {1'b0, v} + {8'h00, p[FLAG_C]};
            p[FLAG_C] = sum[8];
            p[FLAG_V] = ~(acc[7] ^ v[7]) & (acc[7] ^ sum[7]);
            acc = sum[7:0];
            set_nz(acc);
        endfunction

        function void compare(logic [7:0] r, logic [7:0] v);
            p[FLAG_C] = (r >= v);
            set_nz(r - v);
        endfunction

        // shifts and rotates move C; inc/dec leave it alone
        function logic [7:0] shift_or_step(t_rmw kind, logic [7:0] v);
            logic [7:0] r;
            logic       cin;
            cin = p[FLAG_C];
            case (kind)
                RMW_ASL: begin p[FLAG_C] = v[7]; r = {v[6:0], 1'b0}; end
                RMW_LSR: begin p[FLAG_C] = v[0]; r = {1'b0, v[7:1]}; end
                RMW_ROL: begin p[FLAG_C] = v[7]; r = {v[6:0], cin}; end
                RMW_ROR: begin p[FLAG_C] = v[0]; r = {cin, v[7:1]}; end
                RMW_INC: r = v + 8'd1;
                default: r = v - 8'd1;
            endcase
            set_nz(r);
            return r;
        endfunction

        function void note_issue(t_op op, logic [7:0] m, logic amode);
            t_step_out  r;
            logic [7:0] pre, t;
            logic       rmw_on;
            t_rmw       rmw_kind;
            r = '0;
            r.wkind = WK_NONE;
            pre = p;
            rmw_on = 1'b0;
            rmw_kind = RMW_ASL;
            if (!halt) begin
                case (op)
                    OP_ADC: add_to_acc(m);
                    OP_AND: begin acc = acc & m; set_nz(acc); end
                    OP_ASL: begin rmw_on = 1'b1; rmw_kind = RMW_ASL; end
                    OP_BCC: r.taken = !pre[FLAG_C];
                    OP_BCS: r.taken = pre[FLAG_C];
                    OP_BEQ: r.taken = pre[FLAG_Z];
                    OP_BIT: begin
                        p[FLAG_Z] = ((acc & m) == 8'h00);
                        p[FLAG_V] = m[6];
                        p[FLAG_N] = m[7];
                    end
                    OP_BMI: r.taken = pre[FLAG_N];
                    OP_BNE: r.taken = !pre[FLAG_Z];
                    OP_BPL: r.taken = !pre[FLAG_N];
                    OP_BVC: r.taken = !pre[FLAG_V];
                    OP_BVS: r.taken = pre[FLAG_V];
                    OP_CLC: p[FLAG_C] = 1'b0;
                    OP_CLD: p[FLAG_D] = 1'b0;
                    OP_CLI: p[FLAG_I] = 1'b0;
                    OP_CLV: p[FLAG_V] = 1'b0;
                    OP_CMP: compare(acc, m);
                    OP_CPX: compare(ix, m);
                    OP_CPY: compare(iy, m);
                    OP_DEC: begin rmw_on = 1'b1; rmw_kind = RMW_DEC; end
                    OP_DEX: begin ix = ix - 8'd1; set_nz(ix); end
                    OP_DEY: begin iy = iy - 8'd1; set_nz(iy); end
                    OP_EOR: begin acc = acc ^ m; set_nz(acc); end
                    OP_INC: begin rmw_on = 1'b1; rmw_kind = RMW_INC; end
                    OP_INX: begin ix = ix + 8'd1; set_nz(ix); end
                    OP_INY: begin iy = iy + 8'd1; set_nz(iy); end
                    OP_LDA: begin acc = m; set_nz(m); end
                    OP_LDX: begin ix = m; set_nz(m); end
                    OP_LDY: begin iy = m; set_nz(m); end
                    OP_LSR: begin rmw_on = 1'b1; rmw_kind = RMW_LSR; end
                    OP_NOP: ;
                    OP_ORA: begin acc = acc | m; set_nz(acc); end
                    OP_PHA: begin r.wkind = WK_PUSH; r.wdata = acc; sp = sp - 8'd1; end
                    OP_PHP: begin
                        r.wkind = WK_PUSH;
                        r.wdata = p;
                        r.wdata[FLAG_B] = 1'b1;
                        r.wdata[FLAG_U] = 1'b1;
                        sp = sp - 8'd1;
                    end
                    OP_PLA: begin sp = sp + 8'd1; acc = m; set_nz(m); end
                    OP_PLP: begin sp = sp + 8'd1; p = m; end
                    OP_ROL: begin rmw_on = 1'b1; rmw_kind = RMW_ROL; end
                    OP_ROR: begin rmw_on = 1'b1; rmw_kind = RMW_ROR; end
                    OP_SBC: add_to_acc(~m);
                    OP_SEC: p[FLAG_C] = 1'b1;
                    OP_SED: p[FLAG_D] = 1'b1;
                    OP_SEI: p[FLAG_I] = 1'b1;
                    OP_STA: begin r.wkind = WK_EA; r.wdata = acc; end
                    OP_STX: begin r.wkind = WK_EA; r.wdata = ix; end
                    OP_STY: begin r.wkind = WK_EA; r.wdata = iy; end
                    OP_TAX: begin ix = acc; set_nz(ix); end
                    OP_TAY: begin iy = acc; set_nz(iy); end
                    OP_TSX: begin ix = sp; set_nz(ix); end
                    OP_TXA: begin acc = ix; set_nz(acc); end
                    OP_TXS: sp = ix;
                    OP_TYA: begin acc = iy; set_nz(acc); end
                    OP_SLO: begin
                        t = shift_or_step(RMW_ASL, m);
                        r.wkind = WK_EA; r.wdata = t;
                        acc = acc | t; set_nz(acc);
                    end
                    OP_RLA: begin
                        t = shift_or_step(RMW_ROL, m);
                        r.wkind = WK_EA; r.wdata = t;
                        acc = acc & t; set_nz(acc);
                    end
                    OP_SAX: begin r.wkind = WK_EA; r.wdata = acc & ix; end
                    OP_SRE: begin
                        t = shift_or_step(RMW_LSR, m);
                        r.wkind = WK_EA; r.wdata = t;
                        acc = acc ^ t; set_nz(acc);
                    end
                    OP_RRA: begin
                        t = shift_or_step(RMW_ROR, m);
                        r.wkind = WK_EA; r.wdata = t;
                        add_to_acc(t);
                    end
                    OP_LAX, OP_LXA: begin acc = m; ix = m; set_nz(m); end
                    OP_DCP: begin
                        t = shift_or_step(RMW_DEC, m);
                        r.wkind = WK_EA; r.wdata = t;
                        compare(acc, t);
                    end
                    OP_ISC: begin
                        t = shift_or_step(RMW_INC, m);
                        r.wkind = WK_EA; r.wdata = t;
                        add_to_acc(~t);
                    end
                    OP_ANC: begin acc = acc & m; p[FLAG_C] = acc[7]; set_nz(acc); end
                    OP_ASR: begin
                        acc = acc & m;
                        p[FLAG_C] = acc[0];
                        acc = {1'b0, acc[7:1]};
                        set_nz(acc);
                    end
                    OP_ARR: begin
                        t = acc & m;
                        acc = {pre[FLAG_C], t[7:1]};
                        p[FLAG_C] = acc[6];
                        p[FLAG_V] = acc[6] ^ acc[5];
                        set_nz(acc);
                    end
                    OP_ANE: begin acc = ix & m; set_nz(acc); end
                    OP_AXS: begin
                        t = acc & ix;
                        ix = t - m;
                        compare(t, m);
                    end
                    OP_HLT: halt = 1'b1;
                    default: ;
                endcase
                if (rmw_on) begin
                    if (amode) begin
                        acc = shift_or_step(rmw_kind, acc);
                    end else begin
                        r.wkind = WK_EA;
                        r.wdata = shift_or_step(rmw_kind, m);
                    end
                end
                p[FLAG_B] = 1'b0;
                p[FLAG_U] = 1'b1;
            end
            r.acc = acc;
            r.ix = ix;
            r.iy = iy;
            r.sp = sp;
            r.p = p;
            r.halt = halt;
            issued++;
            if (r.wkind != WK_NONE) writes++;
            if (r.taken) taken++;
            due_q.push_back(r);
        endfunction

        function void check_field(string what, int unsigned want_v, int unsigned got_v);
            if (want_v != got_v) begin
                failures++;
                $display("%0t ns: %s mismatch, expected %02h, got %02h",
                         $time, what, want_v, got_v);
            end
        endfunction

        function void check_retire(t_step_out got);
            t_step_out want;
            if (due_q.size() == 0) begin
                failures++;
                $display("%0t ns: result item with no item outstanding", $time);
                return;
            end
            want = due_q.pop_front();
            retired++;
            check_field("write_kind", want.wkind, got.wkind);
            check_field("write_data", want.wdata, got.wdata);
            check_field("branch_taken", want.taken, got.taken);
            check_field("acc_out", want.acc, got.acc);
            check_field("index_x_out", want.ix, got.ix);
            check_field("index_y_out", want.iy, got.iy);
            check_field("stack_ptr_out", want.sp, got.sp);
            check_field("flags_out", want.p, got.p);
            check_field("halted", want.halt, got.halt);
        endfunction
    endclass

    // Opcodes past HLT decode to nothing
    localparam t_op OP_FIRST_UNUSED = 7'd66;
    localparam t_op OP_LAST_UNUSED  = 7'd127;
    localparam int  RANDOM_ITEMS    = 600;
    localparam int  DRAIN_CYCLES    = 8;    // margin for a stray result after the last one

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_op        i_opcode;
    logic [7:0] i_operand_value;
    logic       i_accumulator_mode;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [1:0] o_write_kind;
    logic [7:0] o_write_data;
    logic       o_branch_taken;
    logic [7:0] o_acc_out;
    logic [7:0] o_index_x_out;
    logic [7:0] o_index_y_out;
    logic [7:0] o_stack_ptr_out;
    logic [7:0] o_flags_out;
    logic       o_halted;

    // Shared by sender and receiver: when clear, both sides run back to back
    bit idle_on = 1'b1;

    regfile_tracker trk = new();

    cpu6502_execute_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_opcode           (i_opcode),
        .i_operand_value    (i_operand_value),
        .i_accumulator_mode (i_accumulator_mode),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_write_kind       (o_write_kind),
        .o_write_data       (o_write_data),
        .o_branch_taken     (o_branch_taken),
        .o_acc_out          (o_acc_out),
        .o_index_x_out      (o_index_x_out),
        .o_index_y_out      (o_index_y_out),
        .o_stack_ptr_out    (o_stack_ptr_out),
        .o_flags_out        (o_flags_out),
        .o_halted           (o_halted)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Both channels are observed at the rising edge. An accepted item feeds
    // the tracker; an accepted result is checked against the oldest one due.
    always @(posedge i_clk) begin
        t_step_out got;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got.wkind = t_wkind'(o_write_kind);
                got.wdata = o_write_data;
                got.taken = o_branch_taken;
                got.acc = o_acc_out;
                got.ix = o_index_x_out;
                got.iy = o_index_y_out;
                got.sp = o_stack_ptr_out;
                got.p = o_flags_out;
                got.halt = o_halted;
                trk.check_retire(got);
            end
            if (i_in_valid && o_in_ready)
                trk.note_issue(i_opcode, i_operand_value, i_accumulator_mode);
        end
    end

    // Operand picker: boundary bytes about five times in eight
    function automatic logic [7:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            4: return 8'h01;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Present one item. Called at a falling edge, returns at a falling edge.
    // With a zero gap valid simply stays high into the next item.
    task automatic send_op(input t_op op, input logic [7:0] val, input logic amode);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_operand_value <= val;
        i_accumulator_mode <= amode;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic send_random_op(input bit allow_unused, output bit was_unused);
        t_op op;
        was_unused = allow_unused && ($urandom_range(0, 11) == 0);
        if (was_unused)
            op = t_op'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
        else
            op = t_op'($urandom_range(OP_ADC, OP_AXS));
        send_op(op, pick_operand(), $urandom_range(0, 1) == 1);
    endtask

    // Result side: a fresh random stall before each result item while idle_on is set
    initial begin : result_sink
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int counted;
        bit skipped;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_opcode = OP_NOP;
        i_operand_value = 8'h00;
        i_accumulator_mode = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed part ---
        send_op(OP_LDA, 8'h00, 1'b0);       // zero result sets Z
        send_op(OP_LDA, 8'h7F, 1'b0);
        send_op(OP_ADC, 8'h01, 1'b0);       // 7F + 01: signed overflow, N set
        send_op(OP_SBC, 8'hFF, 1'b0);       // borrow in, borrow out
        send_op(OP_SED, 8'h00, 1'b0);       // decimal flag on...
        send_op(OP_ADC, 8'h09, 1'b0);       // ...but the add stays binary
        send_op(OP_CLD, 8'h00, 1'b0);
        send_op(OP_LDX, 8'h00, 1'b0);
        send_op(OP_TXS, 8'h00, 1'b0);       // SP = 00
        send_op(OP_PHA, 8'h00, 1'b0);       // push wraps SP down to FF
        send_op(OP_PLA, 8'h80, 1'b0);       // pull wraps SP back to 00
        send_op(OP_PHP, 8'h00, 1'b0);       // pushed status carries B and bit 5
        send_op(OP_PLP, 8'hFF, 1'b0);       // pulled B is dropped
        send_op(OP_PLP, 8'h00, 1'b0);       // bit 5 forced back on
        send_op(OP_STA, 8'h00, 1'b1);       // mode bit ignored by stores
        send_op(OP_ROL, 8'h00, 1'b1);       // rotate A, no write
        send_op(OP_ASL, 8'h80, 1'b0);       // memory shift, carry out
        send_op(OP_INC, 8'h00, 1'b1);       // increment A
        send_op(OP_DEC, 8'h00, 1'b0);       // 00 - 1 written back
        send_op(OP_ANE, 8'hFF, 1'b0);       // A = X & operand
        send_op(OP_LXA, 8'h5A, 1'b0);       // A = X = operand
        send_op(OP_ARR, 8'hFF, 1'b0);
        send_op(OP_AXS, 8'h01, 1'b0);
        send_op(OP_SLO, 8'h80, 1'b1);       // undocumented RMW always hits memory
        send_op(OP_FIRST_UNUSED, 8'hFF, 1'b1);
        send_op(OP_LAST_UNUSED, 8'h00, 1'b0);

        // --- random part: everything but HLT, a few unused opcodes mixed in ---
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if (counted % 50 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            send_random_op(1'b1, skipped);
            if (!skipped)
                counted++;
        end

        // --- halt: HLT, then items that must leave every register untouched ---
        idle_on = 1'b1;
        send_op(OP_HLT, pick_operand(), 1'b0);
        send_op(OP_PHA, 8'h00, 1'b0);
        send_op(OP_ASL, 8'h80, 1'b1);
        send_op(OP_BNE, 8'h00, 1'b0);
        repeat (6) send_random_op(1'b1, skipped);
        i_in_valid <= 1'b0;

        // Wait for the last result, then give a stray one time to show up
        while (trk.due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d of %0d items: %0d writes or pushes, %0d taken branches.",
                 trk.retired, trk.issued, trk.writes, trk.taken);
        $display("Directed corners, random operations and the halted state exercised.");
        if (trk.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this
    initial begin : watchdog
        #2_000_000;
        $display("Run timed out");
        $display("Regression FAIL");
        $finish;
    end

endmodule
